// File: rtl/nnu_pkg.sv
// Shared types and constants for the nearest-neighbor upscaler.
`default_nettype none
package nnu_pkg;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam int  APB_AW       = 4;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FACTOR = 2'd2;

    localparam logic [6:0] FACTOR_LIMIT = 7'd100;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [10:0] input_width;
        logic [15:0] input_height;
        logic [6:0]  scale_factor;
    } nnu_cfg_t;

    typedef struct packed {
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       frame_end;
    } nnu_flags_t;

endpackage
`default_nettype wire

// File: rtl/nnu_cfg_regs.sv
// APB configuration registers of the upscaler.
`default_nettype none
module nnu_cfg_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [nnu_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output nnu_pkg::nnu_cfg_t              cfg
);
    import nnu_pkg::*;

    nnu_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_width  <= 11'd1;
            cfg_reg.input_height <= 16'd1;
            cfg_reg.scale_factor <= 7'd1;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_WIDTH:  cfg_reg.input_width  <= pwdata[10:0];
                REG_HEIGHT: cfg_reg.input_height <= pwdata[15:0];
                REG_FACTOR: cfg_reg.scale_factor <= pwdata[6:0];
                default:    ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_WIDTH:  prdata = {21'd0, cfg_reg.input_width};
            REG_HEIGHT: prdata = {16'd0, cfg_reg.input_height};
            REG_FACTOR: prdata = {25'd0, cfg_reg.scale_factor};
            default:    prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/nnu_line_buf.sv
// One-row line buffer: one write port, one registered read port.
`default_nettype none
module nnu_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire nnu_pkg::pixel_t wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output nnu_pkg::pixel_t    rd_data
);
    import nnu_pkg::*;

    pixel_t mem [DEPTH];
    pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/nnu_seq.sv
// Load and raster counters; buffer addresses and row/frame flags.
`default_nettype none
module nnu_seq #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW        = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire nnu_pkg::nnu_cfg_t cfg,
    input  wire logic          load_fire,
    input  wire logic          emit_fire,
    output logic [AW-1:0]      wr_addr,
    output logic [AW-1:0]      rd_addr,
    output nnu_pkg::nnu_flags_t flags
);
    import nnu_pkg::*;

    logic [AW-1:0] load_pos_reg,  load_pos_next;
    logic [AW-1:0] src_col_reg,   src_col_next;
    logic [6:0]    col_rep_reg,   col_rep_next;
    logic [6:0]    row_rep_reg,   row_rep_next;
    logic [15:0]   src_row_reg,   src_row_next;

    logic [AW-1:0] w_last;
    logic [15:0]   h_last;
    logic [6:0]    f_last;
    logic [1:0]    w_lo, f_lo, row_bytes_lo;
    logic          col_last, row_end, rep_last, frame_end;

    // Effective limits, clamped into range
    always_comb
    begin
        if (cfg.input_width == 11'd0)
            w_last = '0;
        else if (32'(cfg.input_width) > 32'(MAX_WIDTH))
            w_last = AW'(MAX_WIDTH - 1);
        else
            w_last = AW'(32'(cfg.input_width) - 32'd1);

        h_last = (cfg.input_height == 16'd0) ? 16'd0 : cfg.input_height - 16'd1;

        if (cfg.scale_factor == 7'd0)
            f_last = 7'd0;
        else if (cfg.scale_factor > FACTOR_LIMIT)
            f_last = FACTOR_LIMIT - 7'd1;
        else
            f_last = cfg.scale_factor - 7'd1;
    end

    // Row padding: only (3*W*F) mod 4 matters
    assign w_lo         = w_last[1:0] + 2'd1;
    assign f_lo         = f_last[1:0] + 2'd1;
    assign row_bytes_lo = 2'(4'(w_lo) * 4'(f_lo) * 4'd3);

    assign col_last  = col_rep_reg >= f_last;
    assign row_end   = col_last && (src_col_reg >= w_last);
    assign rep_last  = row_rep_reg >= f_last;
    assign frame_end = row_end && rep_last && (src_row_reg >= h_last);

    assign flags.row_end   = row_end;
    assign flags.pad_bytes = row_end ? 2'd0 - row_bytes_lo : 2'd0;
    assign flags.frame_end = frame_end;

    assign wr_addr = load_pos_reg;
    assign rd_addr = src_col_reg;

    // Next-state of the counters
    always_comb
    begin
        load_pos_next = load_pos_reg;
        src_col_next  = src_col_reg;
        col_rep_next  = col_rep_reg;
        row_rep_next  = row_rep_reg;
        src_row_next  = src_row_reg;

        if (load_fire)
        begin
            load_pos_next = (load_pos_reg >= w_last) ? '0 : load_pos_reg + 1'b1;
        end

        if (emit_fire)
        begin
            if (frame_end)
            begin
                src_col_next = '0;
                col_rep_next = 7'd0;
                row_rep_next = 7'd0;
                src_row_next = 16'd0;
            end
            else if (row_end)
            begin
                src_col_next = '0;
                col_rep_next = 7'd0;
                if (rep_last)
                begin
                    row_rep_next = 7'd0;
                    src_row_next = src_row_reg + 16'd1;
                end
                else
                begin
                    row_rep_next = row_rep_reg + 7'd1;
                end
            end
            else if (col_last)
            begin
                col_rep_next = 7'd0;
                src_col_next = src_col_reg + 1'b1;
            end
            else
            begin
                col_rep_next = col_rep_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            src_col_reg  <= '0;
            col_rep_reg  <= 7'd0;
            row_rep_reg  <= 7'd0;
            src_row_reg  <= 16'd0;
        end
        else
        begin
            load_pos_reg <= load_pos_next;
            src_col_reg  <= src_col_next;
            col_rep_reg  <= col_rep_next;
            row_rep_reg  <= row_rep_next;
            src_row_reg  <= src_row_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/nearest_neighbor_upscaler_top.sv
// Nearest-neighbor upscaler: a load writes one pixel into the line buffer,
// an emit returns one output pixel via the line buffer read register, then
// the output register. Throughput: one item per cycle unless out_ready stalls
// the output. Loads give no result. Reset clears all counters and sets width,
// height and factor to 1; the line buffer is not cleared.
`default_nettype none
module nearest_neighbor_upscaler_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [nnu_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    // input items
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       opcode,
    input  wire logic [7:0]                 red_in,
    input  wire logic [7:0]                 green_in,
    input  wire logic [7:0]                 blue_in,
    // result items
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [7:0]                 red_out,
    output logic      [7:0]                 green_out,
    output logic      [7:0]                 blue_out,
    output logic                            row_end,
    output logic      [1:0]                 pad_bytes,
    output logic                            frame_end
);
    import nnu_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    nnu_cfg_t      cfg;
    nnu_flags_t    seq_flags;
    logic [AW-1:0] wr_addr, rd_addr;
    pixel_t        wr_pix, rd_pix;
    logic          in_fire, load_fire, emit_fire;
    logic          out_free, s1_move;

    logic          s1_valid_reg, s1_valid_next;
    nnu_flags_t    s1_flags_reg;
    logic          out_valid_reg, out_valid_next;
    pixel_t        out_pix_reg;
    nnu_flags_t    out_flags_reg;

    nnu_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake and pipeline advance
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (opcode == OP_LOAD);
    assign emit_fire = in_fire && (opcode == OP_EMIT);

    assign wr_pix.red   = red_in;
    assign wr_pix.green = green_in;
    assign wr_pix.blue  = blue_in;

    nnu_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .load_fire (load_fire),
        .emit_fire (emit_fire),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .flags     (seq_flags)
    );

    nnu_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (load_fire),
        .wr_addr (wr_addr),
        .wr_data (wr_pix),
        .rd_en   (emit_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_pix)
    );

    // Valid bits of the read stage and the output register
    assign s1_valid_next  = emit_fire || (s1_valid_reg && !s1_move);
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: flags ride alongside the buffer read
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            s1_flags_reg <= seq_flags;
        end
        if (s1_move)
        begin
            out_pix_reg   <= rd_pix;
            out_flags_reg <= s1_flags_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_pix_reg.red;
    assign green_out = out_pix_reg.green;
    assign blue_out  = out_pix_reg.blue;
    assign row_end   = out_flags_reg.row_end;
    assign pad_bytes = out_flags_reg.pad_bytes;
    assign frame_end = out_flags_reg.frame_end;

endmodule
`default_nettype wire

// File: tb/sv/nearest_neighbor_upscaler_top_test.sv
// Self-checking testbench for the nearest-neighbor upscaler top level.
`timescale 1ns / 100ps

module nearest_neighbor_upscaler_top_test;
    import nnu_pkg::*;

    localparam int LINE_WIDTH     = 1024;
    localparam int CLK_HALF       = 5;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 400;
    localparam int PHASE_BUDGET   = 120;
    localparam int HOLD_AFTER     = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 500_000;

    typedef struct packed {
        logic   op;
        pixel_t pix;
    } scaler_item_t;

    typedef struct packed {
        pixel_t     pix;
        nnu_flags_t flags;
    } out_pixel_t;

    typedef enum {RX_STEADY, RX_HALF, RX_SPARSE, RX_BUSY} rx_mode_t;

    // DUT connections
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              opcode    = OP_LOAD;
    logic [7:0]        red_in    = '0;
    logic [7:0]        green_in  = '0;
    logic [7:0]        blue_in   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic              row_end;
    logic [1:0]        pad_bytes;
    logic              frame_end;

    nearest_neighbor_upscaler_top #(.MAX_WIDTH(LINE_WIDTH)) u_top (.*);

    // Item queues and counters
    scaler_item_t pending_items[$];
    out_pixel_t   expected_pixels[$];
    int unsigned  items_queued = 0;
    int unsigned  result_count = 0;
    int unsigned  error_count  = 0;

    // Upscaler state as the predictor sees it
    pixel_t      row_store[LINE_WIDTH];
    logic [10:0] load_pos = '0;
    logic [9:0]  src_col  = '0;
    logic [6:0]  col_rep  = '0;
    logic [6:0]  row_rep  = '0;
    logic [15:0] src_row  = '0;
    nnu_cfg_t    cfg;

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic pixel_t random_pixel();
        return pixel_t'(24'($urandom));
    endfunction

    // Register values clamped to what the block actually uses
    function automatic void active_dims(output int unsigned w, output int unsigned h,
                                        output int unsigned f);
        w = cfg.input_width;
        h = cfg.input_height;
        f = cfg.scale_factor;
        if (w == 0) w = 1;
        else if (w > LINE_WIDTH) w = LINE_WIDTH;
        if (h == 0) h = 1;
        if (f == 0) f = 1;
        else if (f > FACTOR_LIMIT) f = FACTOR_LIMIT;
    endfunction

    // Queue a load and update the line buffer copy
    task automatic queue_load(input pixel_t px);
        int unsigned w, h, f;
        active_dims(w, h, f);
        pending_items.push_back('{op: OP_LOAD, pix: px});
        items_queued++;
        if (load_pos < LINE_WIDTH) row_store[load_pos] = px;
        if (load_pos >= w - 1) load_pos = '0;
        else load_pos++;
    endtask

    // Queue an emit, predict its output pixel and advance the raster counters
    task automatic queue_emit(output nnu_flags_t flags);
        int unsigned w, h, f;
        logic        col_last;
        logic        rep_last;
        out_pixel_t  res;
        active_dims(w, h, f);
        pending_items.push_back('{op: OP_EMIT, pix: random_pixel()});
        items_queued++;
        col_last = col_rep >= f - 1;
        rep_last = row_rep >= f - 1;
        res.pix = row_store[src_col];
        res.flags.row_end = col_last && src_col >= w - 1;
        res.flags.frame_end = res.flags.row_end && rep_last && src_row >= h - 1;
        res.flags.pad_bytes = res.flags.row_end ? 2'((4 - (3 * w * f) % 4) % 4) : 2'd0;
        expected_pixels.push_back(res);
        flags = res.flags;
        if (res.flags.frame_end)
        begin
            src_col = '0;
            col_rep = '0;
            row_rep = '0;
            src_row = '0;
        end
        else if (res.flags.row_end)
        begin
            src_col = '0;
            col_rep = '0;
            if (rep_last)
            begin
                row_rep = '0;
                src_row++;
            end
            else row_rep++;
        end
        else if (col_last)
        begin
            col_rep = '0;
            src_col++;
        end
        else col_rep++;
    endtask

    // Wait until every item is in and every result is out, then let the pipe drain
    task automatic settle();
        while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [10:0] w, input logic [15:0] h, input logic [6:0] f);
        settle();
        write_reg(REG_WIDTH, 32'(w));
        write_reg(REG_HEIGHT, 32'(h));
        write_reg(REG_FACTOR, 32'(f));
        cfg = '{input_width: w, input_height: h, scale_factor: f};
    endtask

    // Well-formed image: load a source row, then emit its replicated output rows
    task automatic run_frames(input int unsigned budget);
        int unsigned w, h, f;
        int unsigned first;
        int unsigned frames;
        int unsigned rows_done;
        bit          group_done;
        nnu_flags_t  flags;
        active_dims(w, h, f);
        first = items_queued;
        frames = $urandom_range(1, 3);
        while (frames != 0 && items_queued - first < budget)
        begin
            for (int i = 0; i < w && items_queued - first < budget; i++)
                queue_load(random_pixel());
            rows_done = 0;
            group_done = 1'b0;
            while (!group_done && items_queued - first < budget)
            begin
                queue_emit(flags);
                if (flags.frame_end)
                begin
                    frames--;
                    group_done = 1'b1;
                end
                else if (flags.row_end)
                begin
                    rows_done++;
                    group_done = rows_done >= f;
                end
            end
        end
    endtask

    // Loads and emits in random order
    task automatic run_noise(input int unsigned count);
        nnu_flags_t flags;
        repeat (count)
        begin
            if ($urandom_range(0, 1) == 0) queue_load(random_pixel());
            else queue_emit(flags);
        end
    endtask

    // Stimulus and end of run
    initial
    begin : stimulus
        int unsigned base;
        logic [10:0] w;
        logic [15:0] h;
        logic [6:0]  f;
        nnu_flags_t  flags;
        cfg = '{input_width: 11'd1, input_height: 16'd1, scale_factor: 7'd1};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: one-pixel rows, so every emit ends a row and the image
        queue_load(pixel_t'(24'h000000));
        queue_emit(flags);
        queue_load(pixel_t'(24'hFFFFFF));
        queue_emit(flags);
        queue_emit(flags);
        // each load wraps at width 1, only the last one survives
        queue_load(pixel_t'(24'hFF0000));
        queue_load(pixel_t'(24'h00FF00));
        queue_load(pixel_t'(24'h0000FF));
        queue_emit(flags);
        queue_load(pixel_t'(24'hA55AC3));
        queue_emit(flags);

        // Width above range clamps to the full buffer; zero height and factor act as 1.
        // One load past the full row wraps back to the first entry.
        configure(11'd2047, 16'd0, 7'd0);
        repeat (LINE_WIDTH + 1) queue_load(random_pixel());
        repeat (4) queue_emit(flags);

        // Factor above range, tallest image, stopped mid-frame
        configure(11'd1, 16'hFFFF, 7'd127);
        queue_load(random_pixel());
        repeat (120) queue_emit(flags);

        // The column repeat counter now sits past the new factor and must wrap at once
        configure(11'd1024, 16'd2, 7'd2);
        repeat (12) queue_emit(flags);

        // Random settings, mostly small images
        base = items_queued;
        while (items_queued - base < RANDOM_ITEMS)
        begin
            w = 11'($urandom_range(1, 8));
            h = 16'($urandom_range(1, 3));
            f = 7'($urandom_range(1, 4));
            if ($urandom_range(0, 7) == 0)
                w = ($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(9, 2047));
            if ($urandom_range(0, 7) == 0)
                h = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(4, 65535));
            if ($urandom_range(0, 7) == 0)
                f = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(5, 127));
            configure(w, h, f);
            if ($urandom_range(0, 5) == 0) run_noise($urandom_range(10, 40));
            else run_frames(PHASE_BUDGET);
        end

        settle();
        if (error_count == 0)
            $display("nearest_neighbor_upscaler_top_test passed");
        else
            $display("nearest_neighbor_upscaler_top_test failed");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("nearest_neighbor_upscaler_top_test failed");
        $finish;
    end

    // Input side: items go out in bursts separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    logic        in_taken   = 1'b0;

    always @(posedge clk) in_taken <= in_valid && in_ready;

    always @(negedge clk)
    begin : driver
        scaler_item_t item;
        // hold the current item until it has been taken
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (gap_left != 0 || pending_items.size() == 0)
            begin
                if (gap_left != 0) gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                item = pending_items.pop_front();
                opcode   <= item.op;
                red_in   <= item.pix.red;
                green_in <= item.pix.green;
                blue_in  <= item.pix.blue;
                in_valid <= 1'b1;
                if (burst_left != 0) burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 47);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // Output side: ready follows a changing pattern, with one long hold-off
    int unsigned hold_left      = 0;
    int unsigned mode_left      = 0;
    bit          long_hold_done = 1'b0;
    rx_mode_t    ready_mode     = RX_STEADY;

    always @(negedge clk)
    begin : receiver
        logic ready_next;
        if (hold_left != 0)
        begin
            hold_left--;
            ready_next = 1'b0;
        end
        else if (!long_hold_done && result_count >= HOLD_AFTER)
        begin
            // back-pressure long enough to fill the block and stall its input
            long_hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            ready_next = 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 200);
            end
            else mode_left--;
            case (ready_mode)
                RX_STEADY: ready_next = 1'b1;
                RX_HALF:   ready_next = $urandom_range(0, 1) == 1;
                RX_SPARSE: ready_next = $urandom_range(0, 3) == 0;
                default:   ready_next = $urandom_range(0, 3) != 0;
            endcase
        end
        out_ready <= ready_next;
    end

    // Result checking
    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        out_pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (expected_pixels.size() == 0)
            begin
                $error("output pixel %0h_%0h_%0h with no emit pending",
                       red_out, green_out, blue_out);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("red_out", want.pix.red, red_out);
                check_field("green_out", want.pix.green, green_out);
                check_field("blue_out", want.pix.blue, blue_out);
                check_field("row_end", 8'(want.flags.row_end), 8'(row_end));
                check_field("pad_bytes", 8'(want.flags.pad_bytes), 8'(pad_bytes));
                check_field("frame_end", 8'(want.flags.frame_end), 8'(frame_end));
            end
        end
    end

endmodule

// File: filelist.f
rtl/nnu_pkg.sv
rtl/nnu_cfg_regs.sv
rtl/nnu_line_buf.sv
rtl/nnu_seq.sv
rtl/nearest_neighbor_upscaler_top.sv
tb/sv/nearest_neighbor_upscaler_top_test.sv
